FILE: design/pfa_pkg.sv
// pfa_pkg: shared codes and types for the partition fit allocator
// used by pfa_select and partition_fit_allocator_unit; no dependencies
package pfa_pkg;

   localparam int REQ_W = 32;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int STATUS_W = 2;
   localparam int CHOSEN_W = 4;
   localparam int ENTRY_W = 4;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_NEXT  = 2'd1;
   localparam logic [1:0] POLICY_BEST  = 2'd2;
   localparam logic [1:0] POLICY_WORST = 2'd3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ALLOC   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PART_COUNT = 1'd1;

   localparam logic [CSR_DATA_W-1:0] PART_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic       clear;
      logic       sample;
      logic [1:0] policy;
   } sel_ctrl_type;

   typedef struct packed {
      logic found;
      logic grant;
   } sel_status_type;

endpackage

FILE: design/pfa_ram.sv
// pfa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pfa_select.sv
// pfa_select: running candidate tracker for the size table scan
// depends on pfa_pkg for policy codes and control/status structs
module pfa_select #(
   parameter int IDX_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pfa_pkg::sel_ctrl_type        ctrl,
   input  logic [pfa_pkg::REQ_W-1:0]    req_size,
   input  logic [IDX_W-1:0]             cand_idx,
   input  logic [pfa_pkg::REQ_W-1:0]    cand_size,
   output pfa_pkg::sel_status_type      status,
   output logic [IDX_W-1:0]             pick,
   output logic [pfa_pkg::REQ_W-1:0]    pick_size
);

   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          pick_ff, pick_in;
   logic [pfa_pkg::REQ_W-1:0] size_ff, size_in;
   logic                      hit;
   logic                      take;

   assign hit = cand_size >= req_size;

   always_comb begin
      unique case (ctrl.policy)
         pfa_pkg::POLICY_FIRST,
         pfa_pkg::POLICY_NEXT:  take = hit && !found_ff;
         pfa_pkg::POLICY_BEST:  take = hit && (!found_ff || cand_size < size_ff);
         pfa_pkg::POLICY_WORST: take = !found_ff || cand_size > size_ff;
         default:               take = 1'b0;
      endcase
   end

   always_comb begin
      found_in = found_ff;
      pick_in  = pick_ff;
      size_in  = size_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (ctrl.sample && take) begin
         found_in = 1'b1;
         pick_in  = cand_idx;
         size_in  = cand_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pick_ff <= pick_in;
      size_ff <= size_in;
   end

   assign status.found = found_ff;
   assign status.grant = (ctrl.policy == pfa_pkg::POLICY_WORST) ?
                         (found_ff && size_ff >= req_size) : found_ff;
   assign pick      = pick_ff;
   assign pick_size = size_ff;

endmodule

FILE: design/partition_fit_allocator_unit.sv
// partition_fit_allocator_unit: top level of the partition fit allocator
// depends on pfa_pkg, pfa_ram and pfa_select
//
// Requests arrive on req_* (valid/ready). A load request writes one entry
// of the base and size tables and answers in the next cycle. An allocate
// request scans the size table one entry per cycle through the size ram's
// single read port, tracks the candidate for the current fit policy, then
// reads the chosen base and writes back the shrunk size and advanced base.
// A granted allocate passes the scan, wait, decide and update states before
// it answers, one that finds nothing answers from decide, and with no
// entries in use it answers in the next cycle. One request is in work at a
// time; the next is taken once the unit is back in idle and the response
// register is empty or being drained.
// Responses sit in an output register on rsp_* until rsp_ready is high;
// a stalled receiver holds the response and blocks new requests.
// Reset clears the control state, the next fit start entry and the csr
// registers (first fit, 16 entries); table contents are undefined until
// loaded. csr_* writes take effect at once; the user must make them while
// idle, and the block itself does not enforce this.
module partition_fit_allocator_unit #(
   parameter int MAX_PARTITIONS = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [pfa_pkg::ENTRY_W-1:0]          req_entry_index,
   input  logic [31:0]                          req_entry_base,
   input  logic [31:0]                          req_entry_size,
   input  logic [pfa_pkg::REQ_W-1:0]            req_request_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pfa_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pfa_pkg::CHOSEN_W-1:0]         rsp_chosen_partition,
   output logic [31:0]                          rsp_granted_address,
   input  logic                                 csr_write_en,
   input  logic [pfa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int IDX_W = $clog2(MAX_PARTITIONS);
   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
   localparam int WIDE_W = 9;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_WAIT   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               cursor_ff, cursor_in;
   logic [CNT_W-1:0]               issued_ff, issued_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]               rd_idx_ff, rd_idx_in;
   logic [pfa_pkg::REQ_W-1:0]      req_size_ff, req_size_in;
   logic [IDX_W-1:0]               start_ff, start_in;
   logic [IDX_W-1:0]               next_start_ff, next_start_in;
   logic [1:0]                     policy_ff;
   logic [pfa_pkg::CSR_DATA_W-1:0] count_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [pfa_pkg::CHOSEN_W-1:0]   rsp_chosen_ff, rsp_chosen_in;
   logic [31:0]                    rsp_addr_ff, rsp_addr_in;

   logic [WIDE_W-1:0]              used_wide;
   logic [CNT_W-1:0]               used_n;
   logic                           accept;
   logic                           bad_index;
   logic [IDX_W-1:0]               load_idx;
   logic [CNT_W-1:0]               cursor_next;
   logic [CNT_W-1:0]               pick_next;
   logic [CNT_W-1:0]               start_next;
   logic [IDX_W-1:0]               first_start;

   logic                           size_wr_en, base_wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic [pfa_pkg::REQ_W-1:0]      size_wr_data;
   logic [ADDR_BITS-1:0]           base_wr_data;
   logic [pfa_pkg::REQ_W-1:0]      size_rd_data;
   logic [ADDR_BITS-1:0]           base_rd_data;

   pfa_pkg::sel_ctrl_type          sel_ctrl;
   pfa_pkg::sel_status_type        sel_status;
   logic [IDX_W-1:0]               sel_pick;
   logic [pfa_pkg::REQ_W-1:0]      sel_pick_size;

   assign used_wide = (WIDE_W'(count_ff) > WIDE_W'(MAX_PARTITIONS)) ?
                      WIDE_W'(MAX_PARTITIONS) : WIDE_W'(count_ff);
   assign used_n    = used_wide[CNT_W-1:0];

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign bad_index = WIDE_W'(req_entry_index) >= WIDE_W'(MAX_PARTITIONS);
   assign load_idx  = IDX_W'(req_entry_index);

   assign cursor_next = (cursor_ff + CNT_W'(1) == used_n) ? '0 : cursor_ff + CNT_W'(1);
   assign pick_next   = (CNT_W'(sel_pick) + CNT_W'(1) == used_n) ? '0 :
                        CNT_W'(sel_pick) + CNT_W'(1);
   assign start_next  = (CNT_W'(start_ff) + CNT_W'(1) == used_n) ? '0 :
                        CNT_W'(start_ff) + CNT_W'(1);
   assign first_start = (policy_ff == pfa_pkg::POLICY_NEXT &&
                         CNT_W'(next_start_ff) < used_n) ? next_start_ff : '0;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= pfa_pkg::POLICY_FIRST;
         count_ff  <= pfa_pkg::PART_COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            pfa_pkg::CSR_FIT_POLICY: policy_ff <= csr_wdata[1:0];
            pfa_pkg::CSR_PART_COUNT: count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      issued_in     = issued_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      req_size_in   = req_size_ff;
      start_in      = start_ff;
      next_start_in = next_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_addr_in   = rsp_addr_ff;
      size_wr_en    = 1'b0;
      base_wr_en    = 1'b0;
      wr_addr       = load_idx;
      size_wr_data  = req_entry_size;
      base_wr_data  = ADDR_BITS'(req_entry_base);
      sel_ctrl.clear  = 1'b0;
      sel_ctrl.sample = rd_vld_ff;
      sel_ctrl.policy = policy_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_chosen_in = '0;
               rsp_addr_in   = '0;
               if (req_command == pfa_pkg::CMD_LOAD) begin
                  rsp_valid_in = 1'b1;
                  if (bad_index) begin
                     rsp_status_in = pfa_pkg::STATUS_BAD_IDX;
                  end else begin
                     rsp_status_in = pfa_pkg::STATUS_LOADED;
                     size_wr_en    = 1'b1;
                     base_wr_en    = 1'b1;
                  end
               end else if (used_n == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pfa_pkg::STATUS_NOFIT;
               end else begin
                  req_size_in    = req_request_size;
                  start_in       = first_start;
                  cursor_in      = CNT_W'(first_start);
                  issued_in      = '0;
                  sel_ctrl.clear = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            rd_idx_in = cursor_ff[IDX_W-1:0];
            cursor_in = cursor_next;
            issued_in = issued_ff + CNT_W'(1);
            if (issued_ff == used_n - CNT_W'(1)) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sel_status.grant) begin
               if (policy_ff == pfa_pkg::POLICY_NEXT) begin
                  next_start_in = pick_next[IDX_W-1:0];
               end
               state_in = S_UPDATE;
            end else begin
               if (policy_ff == pfa_pkg::POLICY_NEXT) begin
                  next_start_in = start_next[IDX_W-1:0];
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = pfa_pkg::STATUS_NOFIT;
               state_in      = S_IDLE;
            end
         end
         S_UPDATE: begin
            wr_addr       = sel_pick;
            size_wr_en    = 1'b1;
            base_wr_en    = 1'b1;
            size_wr_data  = sel_pick_size - req_size_ff;
            base_wr_data  = base_rd_data + ADDR_BITS'(req_size_ff);
            rsp_valid_in  = 1'b1;
            rsp_status_in = pfa_pkg::STATUS_ALLOC;
            rsp_chosen_in = pfa_pkg::CHOSEN_W'(sel_pick);
            rsp_addr_in   = 32'(base_rd_data);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_vld_ff     <= 1'b0;
         next_start_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         next_start_ff <= next_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cursor_ff     <= cursor_in;
      issued_ff     <= issued_in;
      rd_idx_ff     <= rd_idx_in;
      req_size_ff   <= req_size_in;
      start_ff      <= start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   pfa_ram #(
      .WIDTH (pfa_pkg::REQ_W),
      .DEPTH (MAX_PARTITIONS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (size_wr_en),
      .wr_addr (wr_addr),
      .wr_data (size_wr_data),
      .rd_addr (cursor_ff[IDX_W-1:0]),
      .rd_data (size_rd_data)
   );

   pfa_ram #(
      .WIDTH (ADDR_BITS),
      .DEPTH (MAX_PARTITIONS)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (base_wr_en),
      .wr_addr (wr_addr),
      .wr_data (base_wr_data),
      .rd_addr (sel_pick),
      .rd_data (base_rd_data)
   );

   pfa_select #(
      .IDX_W (IDX_W)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sel_ctrl),
      .req_size  (req_size_ff),
      .cand_idx  (rd_idx_ff),
      .cand_size (size_rd_data),
      .status    (sel_status),
      .pick      (sel_pick),
      .pick_size (sel_pick_size)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_chosen_partition = rsp_chosen_ff;
   assign rsp_granted_address  = rsp_addr_ff;

endmodule

FILE: sim/partition_fit_allocator_unit_tb.sv
// partition_fit_allocator_unit_tb: self-checking testbench for the partition fit allocator
// drives load and allocate requests under all fit policies, mixed table sizes, checks each
// response against an in-house model of the partition table; depends on pfa_pkg and the unit
module partition_fit_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   localparam int PHASE_ITEMS = 58;

   typedef struct packed {
      logic                        command;
      logic [pfa_pkg::ENTRY_W-1:0] index;
      logic [31:0]                 base;
      logic [31:0]                 size;
      logic [pfa_pkg::REQ_W-1:0]   request;
   } alloc_request_type;

   typedef struct packed {
      logic [pfa_pkg::STATUS_W-1:0] status;
      logic [pfa_pkg::CHOSEN_W-1:0] chosen;
      logic [31:0]                  address;
   } grant_type;

   typedef struct packed {
      alloc_request_type req;
      logic              known;
      grant_type         exp;
   } directed_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = pfa_pkg::CMD_LOAD;
   logic [pfa_pkg::ENTRY_W-1:0] req_entry_index = '0;
   logic [31:0] req_entry_base = '0;
   logic [31:0] req_entry_size = '0;
   logic [pfa_pkg::REQ_W-1:0] req_request_size = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [pfa_pkg::STATUS_W-1:0] rsp_status;
   logic [pfa_pkg::CHOSEN_W-1:0] rsp_chosen_partition;
   logic [31:0] rsp_granted_address;
   logic csr_write_en = 1'b0;
   logic [pfa_pkg::CSR_INDEX_W-1:0] csr_index = pfa_pkg::CSR_FIT_POLICY;
   logic [pfa_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   partition_fit_allocator_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_entry_index(req_entry_index),
      .req_entry_base(req_entry_base),
      .req_entry_size(req_entry_size),
      .req_request_size(req_request_size),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_chosen_partition(rsp_chosen_partition),
      .rsp_granted_address(rsp_granted_address),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   bit [31:0] part_base [TABLE_DEPTH];
   bit [31:0] part_size [TABLE_DEPTH];
   bit [3:0]  next_fit_start = '0;
   bit [1:0]  cur_policy = pfa_pkg::POLICY_FIRST;
   bit [4:0]  cur_count = pfa_pkg::PART_COUNT_RESET;

   grant_type expected_grants[$];
   directed_row_type directed_rows[$];
   grant_type oldest_grant;
   int unsigned mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // updates the partition table copy and returns the response for one request
   function automatic grant_type apply_request(input alloc_request_type r);
      grant_type g;
      int n;
      int k;
      int start;
      int best;
      bit found;
      g.status = pfa_pkg::STATUS_LOADED;
      g.chosen = '0;
      g.address = '0;
      if (r.command == pfa_pkg::CMD_LOAD) begin
         part_base[r.index] = r.base;
         part_size[r.index] = r.size;
         return g;
      end
      n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
      found = 1'b0;
      best = 0;
      if (n > 0) begin
         if (cur_policy == pfa_pkg::POLICY_NEXT) begin
            start = (next_fit_start < n) ? int'(next_fit_start) : 0;
            k = start;
            for (int i = 0; i < n && !found; i++) begin
               if (part_size[k] >= r.request) begin
                  found = 1'b1;
                  best = k;
               end else begin
                  k = (k + 1) % n;
               end
            end
            next_fit_start = found ? 4'((best + 1) % n) : 4'((start + 1) % n);
         end else if (cur_policy == pfa_pkg::POLICY_WORST) begin
            for (int i = 1; i < n; i++)
               if (part_size[i] > part_size[best]) best = i;
            found = (part_size[best] >= r.request);
         end else begin
            for (int i = 0; i < n; i++) begin
               if (part_size[i] >= r.request) begin
                  if (!found || (cur_policy == pfa_pkg::POLICY_BEST &&
                                 part_size[i] < part_size[best])) begin
                     best = i;
                     found = 1'b1;
                  end
               end
            end
         end
      end
      if (!found) begin
         g.status = pfa_pkg::STATUS_NOFIT;
         return g;
      end
      g.status = pfa_pkg::STATUS_ALLOC;
      g.chosen = 4'(best);
      g.address = part_base[best];
      part_size[best] = part_size[best] - r.request;
      part_base[best] = part_base[best] + r.request;
      return g;
   endfunction

   function automatic directed_row_type row(input logic cmd, input int idx,
                                            input logic [31:0] base,
                                            input logic [31:0] size,
                                            input logic [31:0] request,
                                            input logic known,
                                            input logic [pfa_pkg::STATUS_W-1:0] status,
                                            input int chosen, input logic [31:0] address);
      directed_row_type d;
      d.req.command = cmd;
      d.req.index = 4'(idx);
      d.req.base = base;
      d.req.size = size;
      d.req.request = request;
      d.known = known;
      d.exp.status = status;
      d.exp.chosen = 4'(chosen);
      d.exp.address = address;
      return d;
   endfunction

   task automatic send_request(input directed_row_type d);
      grant_type predicted;
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= d.req.command;
      req_entry_index <= d.req.index;
      req_entry_base <= d.req.base;
      req_entry_size <= d.req.size;
      req_request_size <= d.req.request;
      do @(posedge clock); while (!req_ready);
      predicted = apply_request(d.req);
      expected_grants.push_back(d.known ? d.exp : predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_status);
            mismatch_count++;
         end else begin
            oldest_grant = expected_grants.pop_front();
            if (rsp_status !== oldest_grant.status) begin
               $error("status expected %0d got %0d", oldest_grant.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_chosen_partition !== oldest_grant.chosen) begin
               $error("chosen_partition expected %0d got %0d", oldest_grant.chosen,
                      rsp_chosen_partition);
               mismatch_count++;
            end
            if (rsp_granted_address !== oldest_grant.address) begin
               $error("granted_address expected %h got %h", oldest_grant.address,
                      rsp_granted_address);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      alloc_request_type r;
      directed_row_type d;
      bit [1:0] phase_policy [12];
      bit [4:0] phase_count [12];

      phase_policy = '{pfa_pkg::POLICY_NEXT, pfa_pkg::POLICY_BEST, pfa_pkg::POLICY_WORST,
                       pfa_pkg::POLICY_FIRST, pfa_pkg::POLICY_NEXT, pfa_pkg::POLICY_BEST,
                       pfa_pkg::POLICY_WORST, pfa_pkg::POLICY_NEXT, pfa_pkg::POLICY_FIRST,
                       pfa_pkg::POLICY_BEST, pfa_pkg::POLICY_WORST, pfa_pkg::POLICY_NEXT};
      phase_count = '{5'd16, 5'd16, 5'd31, 5'd1, 5'd5, 5'd0,
                      5'd17, 5'd1, 5'd8, 5'd3, 5'd16, 5'd31};

      directed_rows.push_back(row(pfa_pkg::CMD_LOAD, 0, 32'h0, 32'h0, 32'h0,
                                  1, pfa_pkg::STATUS_LOADED, 0, 0));
      directed_rows.push_back(row(pfa_pkg::CMD_LOAD, 1, 32'hFFFF_FFF0, 32'h100, 32'h0,
                                  1, pfa_pkg::STATUS_LOADED, 0, 0));
      directed_rows.push_back(row(pfa_pkg::CMD_LOAD, 2, 32'h1000, 32'hFFFF_FFFF, 32'h0,
                                  1, pfa_pkg::STATUS_LOADED, 0, 0));
      for (int i = 3; i < 15; i++)
         directed_rows.push_back(row(pfa_pkg::CMD_LOAD, i, 32'h1_0000 * i, 32'(100 * i),
                                     32'h0, 1, pfa_pkg::STATUS_LOADED, 0, 0));
      directed_rows.push_back(row(pfa_pkg::CMD_LOAD, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                  1, pfa_pkg::STATUS_LOADED, 0, 0));
      // zero request takes the empty first entry and leaves it alone
      directed_rows.push_back(row(pfa_pkg::CMD_ALLOC, 0, 32'h0, 32'h0, 32'h0,
                                  1, pfa_pkg::STATUS_ALLOC, 0, 0));
      directed_rows.push_back(row(pfa_pkg::CMD_ALLOC, 0, 32'h0, 32'h0, 32'h20,
                                  1, pfa_pkg::STATUS_ALLOC, 1, 32'hFFFF_FFF0));
      // base wraps past the top of the address space
      directed_rows.push_back(row(pfa_pkg::CMD_ALLOC, 0, 32'h0, 32'h0, 32'h20,
                                  0, pfa_pkg::STATUS_ALLOC, 0, 0));
      directed_rows.push_back(row(pfa_pkg::CMD_ALLOC, 0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                  1, pfa_pkg::STATUS_ALLOC, 2, 32'h1000));
      directed_rows.push_back(row(pfa_pkg::CMD_ALLOC, 0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                  1, pfa_pkg::STATUS_ALLOC, 15, 32'hFFFF_FFFF));
      directed_rows.push_back(row(pfa_pkg::CMD_ALLOC, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 1, pfa_pkg::STATUS_NOFIT, 0, 0));
      directed_rows.push_back(row(pfa_pkg::CMD_ALLOC, 0, 32'h0, 32'h0, 32'h1,
                                  0, pfa_pkg::STATUS_ALLOC, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int phase = 0; phase < 12; phase++) begin
         wait_drained();
         csr_write_en <= 1'b1;
         csr_index <= pfa_pkg::CSR_FIT_POLICY;
         csr_wdata <= {3'($urandom_range(0, 7)), phase_policy[phase]};
         @(posedge clock);
         cur_policy = phase_policy[phase];
         csr_index <= pfa_pkg::CSR_PART_COUNT;
         csr_wdata <= phase_count[phase];
         @(posedge clock);
         cur_count = phase_count[phase];
         csr_write_en <= 1'b0;
         @(posedge clock);

         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
            default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_drained();
            r.command = ($urandom_range(0, 99) < 70) ? pfa_pkg::CMD_ALLOC : pfa_pkg::CMD_LOAD;
            r.index = 4'($urandom_range(0, TABLE_DEPTH - 1));
            r.base = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                                 : $urandom;
            case ($urandom_range(0, 5))
               0: r.size = $urandom;
               1: r.size = part_size[$urandom_range(0, TABLE_DEPTH - 1)];
               2: r.size = 32'hFFFF_FFFF;
               3: r.size = 32'h0;
               default: r.size = $urandom_range(1, 4000);
            endcase
            case ($urandom_range(0, 6))
               0: r.request = 32'h0;
               1: r.request = $urandom;
               2: r.request = 32'hFFFF_FFFF;
               3: r.request = part_size[$urandom_range(0, TABLE_DEPTH - 1)];
               4: r.request = part_size[$urandom_range(0, TABLE_DEPTH - 1)] + 1;
               default: r.request = $urandom_range(1, 1500);
            endcase
            d.req = r;
            d.known = 1'b0;
            d.exp = '0;
            send_request(d);
         end
      end

      wait_drained();
      if (mismatch_count == 0 && expected_grants.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: partition_fit_allocator_unit.f
design/pfa_pkg.sv
design/pfa_ram.sv
design/pfa_select.sv
design/partition_fit_allocator_unit.sv
sim/partition_fit_allocator_unit_tb.sv
